>>> rtl/lac_pkg.sv
// Package for the lag autocovariance engine: sizes, function codes, the
// command struct to the datapath and its status struct. No dependencies.
`default_nettype none
package lac_pkg;
    localparam int DEPTH    = 4096;
    localparam int AW       = $clog2(DEPTH);
    localparam int CW       = $clog2(DEPTH + 1);
    localparam int MAG_W    = 23;
    localparam int SUM_W    = MAG_W + CW;
    localparam int PROD_W   = 2 * (MAG_W + 1);
    localparam int ACC_W    = 64;
    localparam int ACV_W    = 48;
    localparam int LAG_W    = 12;

    localparam logic [1:0] FN_CLEAR = 2'd0;
    localparam logic [1:0] FN_PUSH  = 2'd1;
    localparam logic [1:0] FN_QUERY = 2'd2;

    typedef struct packed {
        logic clear;
        logic push;
        logic mean_start;
        logic acc_clear;
        logic rd_issue;
        logic acc_add;
        logic div_start;
        logic load_out;
        logic err_out;
    } lac_cmd_t;

    typedef struct packed {
        logic          full;
        logic          lag_bad;
        logic          div_busy;
        logic          walk_last;
    } lac_sts_t;
endpackage
`default_nettype wire

>>> rtl/lag_autocovariance_engine.sv
// Top level of the lag autocovariance engine.
// Depends on lac_pkg, lac_controller, lac_datapath.
`default_nettype none
// Usage:
//  s_axis carries one command per transaction: clear, push or query.
//  m_axis carries one result per query.
//  Pushes and clears can follow back to back.
//  A query at lag k over n samples runs a 36-step mean loop, walks n-k sample
//  pairs at two RAM reads per pair, then runs a 64-step quotient loop. The
//  input is held off until its result is loaded into the output register.
//  A query with lag not below the count gets status 1 in the next cycle.
//  Reset empties the store; no clearing pass is needed since only written
//  entries are ever read. When the receiver stalls the result holds in the
//  output register and no new query is taken until it leaves; pushes and
//  clears still pass.
module lag_autocovariance_engine
    import lac_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // sample[23:0], lag[35:24], zero pad
    input  wire logic [1:0]  s_axis_tuser,  // func[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // lag_echo[11:0], acv[59:12], pad
    output logic             m_axis_tuser   // status
);
    lac_cmd_t          cmd;
    lac_sts_t          sts;
    logic              busy, in_fire, out_fire;
    logic [LAG_W-1:0]  lag_o;
    logic [ACV_W-1:0]  acv_o;
    logic              st_o;

    assign s_axis_tready = !busy;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    lac_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .func      (s_axis_tuser),
        .sts       (sts),
        .out_fire  (out_fire),
        .cmd       (cmd),
        .busy      (busy),
        .out_valid (m_axis_tvalid)
    );

    lac_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sample     (s_axis_tdata[23:0]),
        .lag        (s_axis_tdata[35:24]),
        .sts        (sts),
        .lag_out    (lag_o),
        .acv_out    (acv_o),
        .status_out (st_o)
    );

    assign m_axis_tdata = {4'd0, acv_o, lag_o};
    assign m_axis_tuser = st_o;

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !sts.full) else $error("push into full store");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.clear, cmd.push, cmd.mean_start, cmd.err_out}) <= 1)
        else $error("conflicting commands");
    a_err_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.err_out |=> m_axis_tvalid && m_axis_tuser)
        else $error("error result not shown");
endmodule
`default_nettype wire

>>> rtl/lac_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/lac_divider.sv
// Restoring signed divider, one quotient bit per cycle, truncates to zero.
// Depends on lac_pkg.
`default_nettype none
module lac_divider
    import lac_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [ACC_W-1:0]  dividend,
    input  wire logic              dividend_neg,
    input  wire logic [CW-1:0]     divisor,
    output logic                   busy,
    output logic [ACC_W-1:0]       quotient
);
    localparam int BW = $clog2(ACC_W + 1);
    logic [ACC_W-1:0] q_reg, q_next;
    logic [CW-1:0]    r_reg, r_next;
    logic [CW-1:0]    d_reg;
    logic             neg_reg;
    logic [BW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [CW:0]      trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg, q_reg[ACC_W-1]} - {1'b0, d_reg};
        if (busy_reg)
        begin
            if (!trial[CW])
            begin
                r_next = trial[CW-1:0];
                q_next = {q_reg[ACC_W-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[CW-2:0], q_reg[ACC_W-1]};
                q_next = {q_reg[ACC_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == BW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= BW'(ACC_W);
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend_neg ? (~dividend + 1'b1) : dividend;
            r_reg   <= '0;
            d_reg   <= divisor;
            neg_reg <= dividend_neg;
        end
        else
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? (~q_reg + 1'b1) : q_reg;
endmodule
`default_nettype wire

>>> rtl/lac_datapath.sv
// Datapath: sample store, count, magnitude sum, mean, product accumulator
// and divider. Depends on lac_pkg, lac_ram, lac_divider.
`default_nettype none
module lac_datapath
    import lac_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lac_cmd_t          cmd,
    input  wire logic [23:0]       sample,
    input  wire logic [LAG_W-1:0]  lag,
    output lac_sts_t               sts,
    output logic [LAG_W-1:0]       lag_out,
    output logic [ACV_W-1:0]       acv_out,
    output logic                   status_out
);
    logic [CW-1:0]    count_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [MAG_W-1:0] mag;
    logic [LAG_W-1:0] lag_reg;
    logic [CW-1:0]    terms_reg;
    logic [CW-1:0]    i_reg;
    logic [AW-1:0]    raddr;
    logic             ra_sel_reg;
    logic [MAG_W-1:0] rdata, a_reg;
    logic             a_valid_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [MAG_W:0]   da, db;
    logic             div_busy;
    logic [ACC_W-1:0] quo;
    // mean is produced by a serial divider of the magnitude sum
    logic [SUM_W-1:0] mq_reg;
    logic [CW-1:0]    mr_reg;
    logic [MAG_W-1:0] mean_reg;
    logic [6:0]       mcnt_reg;
    logic [CW:0]      mtrial;
    logic [LAG_W+1:0] lagx;

    assign mag = (sample == 24'h800000) ? {MAG_W{1'b1}} :
                 (sample[23] ? MAG_W'(24'd0 - sample) : sample[MAG_W-1:0]);

    lac_ram #(.WIDTH(MAG_W), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (count_reg[AW-1:0]),
        .wdata (mag),
        .raddr (raddr),
        .rdata (rdata)
    );

    // alternate reads of x[i] and x[i+k]
    assign raddr = ra_sel_reg ? AW'(i_reg + CW'(lag_reg)) : i_reg[AW-1:0];
    assign lagx  = (LAG_W+2)'(lag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else if (cmd.clear)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else if (cmd.push)
        begin
            count_reg <= count_reg + 1'b1;
            sum_reg   <= sum_reg + SUM_W'(mag);
        end
    end

    assign mtrial = {mr_reg, mq_reg[SUM_W-1]} - {1'b0, count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcnt_reg    <= '0;
            ra_sel_reg  <= 1'b0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.mean_start)
            begin
                mcnt_reg <= 7'(SUM_W);
            end
            else if (mcnt_reg != '0)
            begin
                mcnt_reg <= mcnt_reg - 1'b1;
            end
            if (cmd.acc_clear)
            begin
                ra_sel_reg <= 1'b0;
            end
            else if (cmd.rd_issue)
            begin
                ra_sel_reg <= ~ra_sel_reg;
            end
            a_valid_reg <= cmd.rd_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mean_start)
        begin
            lag_reg   <= lag;
            terms_reg <= count_reg - CW'(lag);
            mq_reg    <= sum_reg;
            mr_reg    <= '0;
        end
        else if (mcnt_reg != '0)
        begin
            if (!mtrial[CW])
            begin
                mr_reg <= mtrial[CW-1:0];
                mq_reg <= {mq_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                mr_reg <= {mr_reg[CW-2:0], mq_reg[SUM_W-1]};
                mq_reg <= {mq_reg[SUM_W-2:0], 1'b0};
            end
        end
        mean_reg <= mq_reg[MAG_W-1:0];
        if (cmd.acc_clear)
        begin
            i_reg   <= '0;
            acc_reg <= '0;
        end
        else
        begin
            if (cmd.rd_issue && ra_sel_reg)
            begin
                i_reg <= i_reg + 1'b1;
            end
            // hold the first read of a pair; the second lands in the next cycle
            if (a_valid_reg && ra_sel_reg)
            begin
                a_reg <= rdata;
            end
            if (a_valid_reg && !ra_sel_reg)
            begin
                prod_reg <= PROD_W'($signed(da) * $signed(db));
            end
            if (cmd.acc_add)
            begin
                acc_reg <= acc_reg + ACC_W'($signed(prod_reg));
            end
        end
        if (cmd.load_out)
        begin
            lag_out    <= lag_reg;
            acv_out    <= quo[ACV_W-1:0];
            status_out <= 1'b0;
        end
        else if (cmd.err_out)
        begin
            lag_out    <= lag;
            acv_out    <= '0;
            status_out <= 1'b1;
        end
    end

    assign da = {1'b0, a_reg} - {1'b0, mean_reg};
    assign db = {1'b0, rdata} - {1'b0, mean_reg};

    lac_divider u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (cmd.div_start),
        .dividend     (acc_reg),
        .dividend_neg (acc_reg[ACC_W-1]),
        .divisor      (terms_reg),
        .busy         (div_busy),
        .quotient     (quo)
    );

    assign sts.full      = (count_reg == CW'(DEPTH));
    assign sts.lag_bad   = ((LAG_W+2)'(count_reg) <= lagx);
    assign sts.div_busy  = div_busy || (mcnt_reg != '0);
    assign sts.walk_last = (i_reg == terms_reg - 1'b1);
endmodule
`default_nettype wire

>>> rtl/lac_controller.sv
// Controller state machine: sequences push, clear and query walks.
// Depends on lac_pkg.
`default_nettype none
module lac_controller
    import lac_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_fire,
    input  wire logic [1:0] func,
    input  wire lac_sts_t   sts,
    input  wire logic       out_fire,
    output lac_cmd_t        cmd,
    output logic            busy,
    output logic            out_valid
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MEAN = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DIVW = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [2:0] drain_reg, drain_next;
    logic       ov_reg, ov_next;
    logic       wait_reg, wait_next;
    // accumulate one product for each completed pair, delayed through addpipe_reg
    logic [1:0] addpipe_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        drain_next = drain_reg;
        ov_next    = ov_reg && !out_fire;
        wait_next  = 1'b0;
        cmd.acc_add = addpipe_reg[1];
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (func == FN_CLEAR)
                    begin
                        cmd.clear = 1'b1;
                    end
                    else if (func == FN_PUSH)
                    begin
                        cmd.push = !sts.full;
                    end
                    else if (func == FN_QUERY)
                    begin
                        if (sts.lag_bad)
                        begin
                            cmd.err_out = 1'b1;
                            ov_next     = 1'b1;
                        end
                        else
                        begin
                            cmd.mean_start = 1'b1;
                            wait_next      = 1'b1;
                            state_next     = S_MEAN;
                        end
                    end
                end
            end
            S_MEAN:
            begin
                // wait for the mean register to settle before the walk starts
                if (!sts.div_busy && !wait_reg)
                begin
                    wait_next = 1'b1;
                    if (wait_reg == 1'b0 && drain_reg == 3'd0)
                    begin
                        drain_next = 3'd1;
                    end
                    else
                    begin
                        cmd.acc_clear = 1'b1;
                        drain_next    = 3'd0;
                        state_next    = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                cmd.rd_issue = 1'b1;
                if (drain_reg == 3'd1)
                begin
                    drain_next = 3'd0;
                    if (sts.walk_last)
                    begin
                        state_next = S_DRAIN;
                        drain_next = 3'd3;
                    end
                end
                else
                begin
                    drain_next = 3'd1;
                end
            end
            S_DRAIN:
            begin
                drain_next = drain_reg - 1'b1;
                if (drain_reg == 3'd0)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVW;
                wait_next     = 1'b1;
            end
            S_DIVW:
            begin
                if (!sts.div_busy && !wait_reg && !ov_reg)
                begin
                    cmd.load_out = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            drain_reg   <= '0;
            ov_reg      <= 1'b0;
            wait_reg    <= 1'b0;
            addpipe_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            drain_reg   <= drain_next;
            ov_reg      <= ov_next;
            wait_reg    <= wait_next;
            addpipe_reg <= {addpipe_reg[0],
                            state_reg == S_WALK && drain_reg == 3'd1};
        end
    end

    assign busy      = (state_reg != S_IDLE) || (ov_reg && func == FN_QUERY);
    assign out_valid = ov_reg;
endmodule
`default_nettype wire

>>> tb/lag_autocovariance_engine_tb.sv
// Testbench for lag_autocovariance_engine: drives clear, push and query commands,
// predicts each query's lag autocovariance and checks the results in order.
// Depends on lac_pkg and the RTL of the engine.
`timescale 1ns / 100ps
`default_nettype none
module lag_autocovariance_engine_tb
    import lac_pkg::*;
();
    localparam int IDLE_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;

    typedef struct packed {
        logic [11:0] lag;
        logic [47:0] acv;
        logic        status;
    } acv_result_t;

    typedef struct {
        logic [1:0]  func;
        logic [23:0] sample;
        logic [11:0] lag;
        bit          typed;
        acv_result_t want;
    } stim_row_t;

    // predictor state
    logic [22:0] mag_store [DEPTH];
    int unsigned mag_count;
    longint unsigned mag_sum;

    acv_result_t pending_results[$];
    int          fail_count;
    int          result_count;
    int          query_count;
    int          push_count;
    int          drop_count;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;

    lag_autocovariance_engine u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic [22:0] magnitude(logic [23:0] s);
        if (s == 24'h800000)
            return 23'h7FFFFF;
        return s[23] ? 23'((~s) + 24'd1) : s[22:0];
    endfunction

    // Update the model for one accepted transaction; queue a result for queries.
    function automatic void predict(logic [1:0] func, logic [23:0] s, logic [11:0] lag);
        acv_result_t r;
        longint mean;
        longint acc;
        longint a;
        longint b;
        int unsigned terms;
        case (func)
            FN_CLEAR:
            begin
                mag_count = 0;
                mag_sum = 0;
            end
            FN_PUSH:
            begin
                if (mag_count < DEPTH)
                begin
                    mag_store[mag_count] = magnitude(s);
                    mag_sum += magnitude(s);
                    mag_count++;
                    push_count++;
                end
                else
                begin
                    drop_count++;
                end
            end
            FN_QUERY:
            begin
                r.lag = lag;
                if (lag >= mag_count)
                begin
                    r.acv = '0;
                    r.status = 1'b1;
                end
                else
                begin
                    terms = mag_count - lag;
                    mean = longint'(mag_sum / longint'(mag_count));
                    acc = 0;
                    for (int i = 0; i < terms; i++)
                    begin
                        a = longint'(mag_store[i]) - mean;
                        b = longint'(mag_store[i + lag]) - mean;
                        acc += a * b;
                    end
                    r.acv = 48'(acc / longint'(terms));
                    r.status = 1'b0;
                end
                pending_results = {pending_results, r};
                query_count++;
            end
            default: ;
        endcase
    endfunction

    // Leave tvalid high on return; the next send drives it anew, a drain takes it down.
    task automatic send_item(logic [1:0] func, logic [23:0] s, logic [11:0] lag);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {4'h0, lag, s};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict(func, s, lag);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic push_series(int len, int mode);
        logic [23:0] s;
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                0: s = 24'($urandom);
                1: s = 24'($urandom_range(400, 0)) - 24'd200;
                default: s = $urandom_range(1, 0) ? 24'h7FFFFF : 24'h800000;
            endcase
            send_item(FN_PUSH, s, 12'($urandom));
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !hold_off &&
                !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
    end

    // Checker and watchdog.
    always @(posedge clk)
    begin
        acv_result_t want;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                result_count++;
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result lag_echo=%0d", m_axis_tdata[11:0]);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata[11:0] !== want.lag)
                    begin
                        $error("lag_echo: expected %0d, got %0d", want.lag,
                               m_axis_tdata[11:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[59:12] !== want.acv)
                    begin
                        $error("autocovariance: expected %0d, got %0d",
                               $signed(want.acv), $signed(m_axis_tdata[59:12]));
                        fail_count++;
                    end
                    if (m_axis_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status,
                               m_axis_tuser);
                        fail_count++;
                    end
                end
            end
        end
    end

    stim_row_t directed[$];

    function automatic stim_row_t row(logic [1:0] f, logic [23:0] s, logic [11:0] l,
                                      bit typed = 0, logic [47:0] acv = '0,
                                      logic st = 1'b0);
        stim_row_t r;
        r.func = f;
        r.sample = s;
        r.lag = l;
        r.typed = typed;
        r.want = '{lag: l, acv: acv, status: st};
        return r;
    endfunction

    initial
    begin
        int phase_pct [4][2];
        int hold_cycles;
        phase_pct = '{'{0, 0}, '{59, 0}, '{0, 59}, '{36, 36}};
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = FN_CLEAR;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fail_count = 0;
        result_count = 0;
        query_count = 0;
        push_count = 0;
        drop_count = 0;
        idle_cycles = 0;
        mag_count = 0;
        mag_sum = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty store, extremes, saturated minimum, unused code, clear.
        directed = {directed, row(FN_QUERY, 24'h0, 12'd0, 1, 48'd0, 1'b1)};
        directed = {directed, row(FN_QUERY, 24'h0, 12'hFFF, 1, 48'd0, 1'b1)};
        directed = {directed, row(FN_PUSH, 24'h800000, 12'h0)};
        directed = {directed, row(FN_QUERY, 24'h0, 12'd0, 1, 48'd0, 1'b0)};
        directed = {directed, row(FN_QUERY, 24'h0, 12'd1, 1, 48'd0, 1'b1)};
        directed = {directed, row(FN_PUSH, 24'h000000, 12'hFFF)};
        directed = {directed, row(FN_PUSH, 24'h7FFFFF, 12'h0)};
        directed = {directed, row(FN_PUSH, 24'hFFFFFF, 12'hABC)};
        directed = {directed, row(FN_QUERY, 24'hFFFFFF, 12'd0)};
        directed = {directed, row(FN_QUERY, 24'h0, 12'd1)};
        directed = {directed, row(FN_QUERY, 24'h0, 12'd3)};
        directed = {directed, row(FN_QUERY, 24'h0, 12'd4, 1, 48'd0, 1'b1)};
        directed = {directed, row(2'd3, 24'h123456, 12'h555)};
        directed = {directed, row(FN_QUERY, 24'h0, 12'd2)};
        directed = {directed, row(FN_CLEAR, 24'hFFFFFF, 12'hFFF)};
        directed = {directed, row(FN_QUERY, 24'h0, 12'd0, 1, 48'd0, 1'b1)};
        directed = {directed, row(FN_PUSH, 24'h000001, 12'h0)};
        directed = {directed, row(FN_PUSH, 24'h400000, 12'h0)};
        directed = {directed, row(FN_QUERY, 24'h0, 12'd0)};
        directed = {directed, row(FN_QUERY, 24'h0, 12'd1)};
        foreach (directed[i])
        begin
            send_item(directed[i].func, directed[i].sample, directed[i].lag);
            if (directed[i].typed && pending_results.size() != 0)
                pending_results[$] = directed[i].want;
        end
        drain();

        // Random: per phase, clear, push a short series, then queries and noise.
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = phase_pct[p][0];
            recv_stall_pct = phase_pct[p][1];
            for (int set = 0; set < 3; set++)
            begin
                send_item(FN_CLEAR, 24'($urandom), 12'($urandom));
                push_series($urandom_range(8, 1), $urandom_range(2, 0));
                for (int q = 0; q < 4; q++)
                begin
                    case ($urandom_range(9, 0))
                        0: send_item(2'd3, 24'($urandom), 12'($urandom));
                        1: send_item(FN_PUSH, 24'($urandom), 12'($urandom));
                        2: send_item(FN_QUERY, 24'($urandom), 12'($urandom));
                        default:
                            send_item(FN_QUERY, 24'($urandom),
                                      12'($urandom_range(mag_count + 1, 0)));
                    endcase
                end
            end
            // Pause the sender until every result is back.
            drain();
        end

        // Long receiver hold-off while queries and pushes keep coming.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                hold_cycles = 0;
                while (hold_cycles < 300)
                begin
                    @(posedge clk);
                    hold_cycles++;
                end
                hold_off = 1'b0;
            end
            begin
                for (int q = 0; q < 6; q++)
                begin
                    send_item(FN_QUERY, 24'($urandom), 12'($urandom_range(mag_count, 0)));
                    send_item(FN_PUSH, 24'($urandom), 12'($urandom));
                end
                s_axis_tvalid <= 1'b0;
            end
        join
        drain();
        repeat (200) @(posedge clk);

        $display("Covered %0d accepted pushes (%0d dropped when full),", push_count,
                 drop_count);
        $display("%0d queries and %0d checked results.", query_count, result_count);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

>>> lag_autocovariance_engine.f
rtl/lac_pkg.sv
rtl/lac_ram.sv
rtl/lac_divider.sv
rtl/lac_datapath.sv
rtl/lac_controller.sv
rtl/lag_autocovariance_engine.sv
tb/lag_autocovariance_engine_tb.sv
